>>> design/wfm_pkg.sv
`default_nettype none
package wfm_pkg;
	localparam int CarrierDepth = 64;
	localparam int ModDepth = 32;
	localparam int StepW = 42;
	localparam int AccW = 43;
	localparam logic [StepW-1:0] StepReset = 42'h080_0000_0000;

	typedef enum logic [1:0] {
		KIND_REG = 2'd0,
		KIND_WAVE = 2'd1,
		KIND_READ = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	localparam logic [3:0] REG_VOL = 4'd0;
	localparam logic [3:0] REG_FLO = 4'd2;
	localparam logic [3:0] REG_FHI = 4'd3;
	localparam logic [3:0] REG_MOD = 4'd4;
	localparam logic [3:0] REG_MADDR = 4'd5;
	localparam logic [3:0] REG_MLO = 4'd6;
	localparam logic [3:0] REG_MHI = 4'd7;
	localparam logic [3:0] REG_MTAB = 4'd8;
	localparam logic [3:0] REG_MAST = 4'd9;
	localparam logic [3:0] REG_ENV = 4'd10;

	localparam logic [1:0] CFG_STEP = 2'd0;

	typedef struct packed {
		logic        start;
		logic        done;
	} clk_ctl_t;
endpackage
`default_nettype wire

>>> design/wfm_ram.sv
`default_nettype none
module wfm_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(Depth)-1:0]   waddr,
	input  wire [Width-1:0]           wdata,
	input  wire [$clog2(Depth)-1:0]   raddr,
	output logic [Width-1:0]          rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> design/wfm_accum.sv
`default_nettype none
// bit-serial phase accumulator: adds step, then counts whole chip clocks
module wfm_accum (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [wfm_pkg::StepW-1:0]     step,
	output logic                         busy,
	output logic [2:0]                   clocks
);
	import wfm_pkg::*;
	logic [AccW-1:0] acc_q;
	logic [StepW-1:0] addend_q;
	logic [5:0] cnt_q;
	logic carry_q;
	logic [AccW-1:0] acc_next;
	logic sbit, cout;

	assign sbit = (cnt_q < 6'(StepW)) ? addend_q[0] : 1'b0;
	assign {cout, acc_next[AccW-1]} = 2'(acc_q[0]) + 2'(sbit) + 2'(carry_q);
	assign acc_next[AccW-2:0] = acc_q[AccW-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			busy <= 1'b0;
			carry_q <= 1'b0;
			addend_q <= '0;
			clocks <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= '0;
			carry_q <= 1'b0;
			addend_q <= step;
		end else if (busy) begin
			// one sum bit per cycle, lsb first, rotating the accumulator
			acc_q <= acc_next;
			addend_q <= addend_q >> 1;
			carry_q <= cout;
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(AccW - 1)) begin
				busy <= 1'b0;
				clocks <= acc_next[AccW-1:40];
				acc_q <= {3'b000, acc_next[39:0]};
			end
		end
	end
endmodule
`default_nettype wire

>>> design/wfm_core.sv
`default_nettype none
// one chip clock per call: frequency adder, modulator, envelopes
module wfm_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        go,
	input  wire [7:0]  r0,
	input  wire [7:0]  r2,
	input  wire [7:0]  r3,
	input  wire [7:0]  r4,
	input  wire [7:0]  r6,
	input  wire [7:0]  r7,
	input  wire [7:0]  r10,
	input  wire [2:0]  mod_entry,
	input  wire        gain_wr,
	input  wire        gain_sel,
	input  wire [5:0]  gain_val,
	input  wire        modpos_clr,
	output logic [4:0] mod_addr,
	output logic [5:0] gain0,
	output logic [5:0] gain1,
	output logic [5:0] wave_idx
);
	import wfm_pkg::*;
	logic [2:0] bit_phase_q;
	logic [18:0] freq_shift_q;
	logic [24:0] carrier_pos_q;
	logic [17:0] mod_pos_q;
	logic [7:0] mod_shift_q;
	logic [11:0] presc_q;
	logic [6:0] div_q [2];
	logic [5:0] gain_q [2];

	logic [17:0] mpos_n;
	logic [18:0] fs_n;
	logic [7:0] ms_n;
	logic [24:0] sum;
	logic [8:0] prod;
	logic signed [9:0] adj;
	logic signed [12:0] pdec, padd;
	logic env_go;

	// address the table with the stepped position so the entry is ready in the cycle after go
	assign mod_addr = mpos_n[17:13];
	assign gain0 = gain_q[0];
	assign gain1 = gain_q[1];
	assign wave_idx = carrier_pos_q[24:19];
	assign mpos_n = mod_pos_q + {6'd0, r7[3:0], r6};

	always_comb begin
		prod = '0;
		adj = '0;
		case (mod_entry[1:0])
			2'd1: prod = {3'd0, gain_q[1]};
			2'd2: prod = {2'd0, gain_q[1], 1'b0};
			2'd3: prod = {3'd0, gain_q[1]} + {2'd0, gain_q[1], 1'b0};
			default: prod = '0;
		endcase
		if (mod_entry[1:0] != 2'd0) begin
			if (mod_entry[2])
				adj = -$signed({1'b0, 9'(({3'd0, gain_q[1]} << 2) - prod)}) <<< 1;
			else
				adj = $signed({1'b0, prod}) <<< 1;
		end
		if (bit_phase_q == 3'd0) begin
			fs_n = {7'd0, r3[3:0], r2};
			if (r7[7]) ms_n = 8'h80;
			else if (adj > 10'sd127) ms_n = 8'hff;
			else if (adj < -10'sd128) ms_n = 8'h00;
			else ms_n = 8'(adj + 10'sd128);
		end else begin
			fs_n = freq_shift_q << 1;
			ms_n = mod_shift_q >> 1;
		end
		sum = carrier_pos_q + {6'd0, fs_n};
		pdec = $signed(presc_q) - 13'sd1;
		padd = pdec + $signed({1'b0, 12'({2'd0, r10} + {1'b0, r10, 1'b0})});
		env_go = pdec <= 13'sd0;
	end

	// modulation table entry is read from the registered ram in the cycle after go
	logic go_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			bit_phase_q <= '0;
			freq_shift_q <= '0;
			carrier_pos_q <= '0;
			mod_pos_q <= '0;
			mod_shift_q <= '0;
			presc_q <= '0;
			div_q[0] <= '0;
			div_q[1] <= '0;
			gain_q[0] <= '0;
			gain_q[1] <= '0;
		end else begin
			go_s1 <= go;
			if (go && bit_phase_q == 3'd0) mod_pos_q <= mpos_n;
			if (modpos_clr) mod_pos_q <= '0;
			if (gain_wr) gain_q[gain_sel] <= gain_val;
			if (go_s1) begin
				freq_shift_q <= fs_n;
				mod_shift_q <= ms_n;
				if (ms_n[0]) carrier_pos_q <= sum;
				bit_phase_q <= bit_phase_q + 3'd1;
				if (!env_go) presc_q <= pdec[11:0];
				else if (padd < -13'sd1024) presc_q <= 12'hc00;
				else presc_q <= padd[11:0];
				if (env_go) begin
					for (int x = 0; x < 2; x++) begin
						logic [7:0] r;
						r = (x == 0) ? r0 : r4;
						if (!r[7] && !r3[6]) begin
							if (div_q[x] == 7'd0) begin
								if (r[6]) begin
									if (gain_q[x] < 6'h3f) gain_q[x] <= gain_q[x] + 6'd1;
								end else if (gain_q[x] > 6'd0) gain_q[x] <= gain_q[x] - 6'd1;
								div_q[x] <= {1'b0, r[5:0]};
							end else div_q[x] <= div_q[x] - 7'd1;
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> design/wavetable_fm_sound_channel.sv
`default_nettype none
// channel   dir   payload
// s_axis    in    tuser=kind, tdata=offset,write_data,open_bus
// m_axis    out   tdata=read_data,sample
// apb       in    step_increment at address 0
// a write or read goes straight to the result; a tick runs the serial
// accumulator add, then a go and a wait state per chip clock (up to 4) with
// the wave read after the last one, then two sample states and the result.
// reset clears all state; the tables are cleared by a sweep of all 64 addresses
// after reset during which s_axis_tready is low. a stalled result holds the block.
module wavetable_fm_sound_channel #(
	parameter int CarrierDepth = wfm_pkg::CarrierDepth,
	parameter int ModDepth = wfm_pkg::ModDepth
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [1:0]  s_axis_tuser,  // kind
	input  wire  [23:0] s_axis_tdata,  // offset, write_data, open_bus
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // read_data, sample, zero pad
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import wfm_pkg::*;
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_ACC, S_CLK, S_CLKW, S_WAV, S_SMP, S_SMP2, S_OUT
	} st_t;
	st_t st_q;
	logic [StepW-1:0] step_q;
	logic [7:0] regs_q [11];
	logic [5:0] clr_q;
	logic [2:0] nclk_q;
	logic [7:0] rd_q;
	logic [11:0] smp_q;

	assign pready = 1'b1;
	assign prdata = {22'd0, step_q};

	logic acc_busy, acc_start;
	logic [2:0] acc_clocks;
	wfm_accum u_acc (.clk, .arst_n, .start(acc_start), .step(step_q),
		.busy(acc_busy), .clocks(acc_clocks));

	logic [4:0] mod_addr;
	logic [5:0] gain0, gain1, wave_idx;
	logic [2:0] mod_entry;
	logic [5:0] wave_q;
	logic core_go, item_acc, is_reg, gain_wr, modpos_clr;
	assign item_acc = s_axis_tvalid && s_axis_tready;
	assign is_reg = item_acc && s_axis_tuser == KIND_REG && s_axis_tdata[5:0] <= 6'd10;
	assign gain_wr = is_reg && (s_axis_tdata[5:0] == 6'(REG_VOL) ||
		s_axis_tdata[5:0] == 6'(REG_MOD)) && s_axis_tdata[13];
	assign modpos_clr = is_reg && (s_axis_tdata[5:0] == 6'(REG_MHI) ||
		s_axis_tdata[5:0] == 6'(REG_MTAB));
	assign core_go = st_q == S_CLK;

	wfm_core u_core (.clk, .arst_n, .go(core_go), .r0(regs_q[0]), .r2(regs_q[2]),
		.r3(regs_q[3]), .r4(regs_q[4]), .r6(regs_q[6]), .r7(regs_q[7]),
		.r10(regs_q[10]), .mod_entry, .gain_wr, .gain_sel(s_axis_tdata[2]),
		.gain_val(s_axis_tdata[11:6]), .modpos_clr, .mod_addr, .gain0, .gain1,
		.wave_idx);

	logic clr;
	logic mwe, cwe;
	assign clr = st_q == S_CLR;
	assign mwe = clr || (is_reg && s_axis_tdata[5:0] == 6'(REG_MTAB));
	assign cwe = clr || (item_acc && s_axis_tuser == KIND_WAVE && regs_q[9][7]);
	wfm_ram #(.Width(3), .Depth(ModDepth)) u_mram (.clk, .we(mwe),
		.waddr(clr ? clr_q[$clog2(ModDepth)-1:0] : regs_q[5][$clog2(ModDepth)-1:0]),
		.wdata(clr ? 3'd0 : s_axis_tdata[8:6]), .raddr(mod_addr), .rdata(mod_entry));
	wfm_ram #(.Width(6), .Depth(CarrierDepth)) u_cram (.clk, .we(cwe),
		.waddr(clr ? clr_q : s_axis_tdata[5:0]),
		.wdata(clr ? 6'd0 : s_axis_tdata[11:6]), .raddr(wave_idx), .rdata(wave_q));

	logic [5:0] k;
	logic [13:0] num;
	assign k = (gain0 > 6'h20) ? 6'h20 : gain0;
	assign acc_start = item_acc && s_axis_tuser == KIND_TICK;
	assign s_axis_tready = st_q == S_IDLE;
	assign m_axis_tvalid = st_q == S_OUT;
	assign m_axis_tdata = {4'd0, smp_q, rd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			step_q <= StepReset;
			for (int i = 0; i < 11; i++) regs_q[i] <= '0;
			nclk_q <= '0;
			rd_q <= '0;
			smp_q <= '0;
			num <= '0;
		end else begin
			if (psel && penable && pwrite && paddr[3:2] == CFG_STEP)
				step_q <= pwdata[StepW-1:0];
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'(CarrierDepth - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (item_acc) begin
					rd_q <= '0;
					smp_q <= '0;
					if (is_reg) begin
						regs_q[s_axis_tdata[3:0]] <= s_axis_tdata[13:6];
						if (s_axis_tdata[5:0] == 6'(REG_MHI)) regs_q[REG_MADDR] <= '0;
						if (s_axis_tdata[5:0] == 6'(REG_MTAB))
							regs_q[REG_MADDR] <= {3'd0, 5'(regs_q[REG_MADDR] + 8'd1)};
					end
					if (s_axis_tuser == KIND_READ) begin
						if (s_axis_tdata[5:0] == 6'd0)
							rd_q <= {s_axis_tdata[21:20], gain0};
						else if (s_axis_tdata[5:0] == 6'd2)
							rd_q <= {s_axis_tdata[21:20], gain1};
						else rd_q <= s_axis_tdata[21:14];
					end
					st_q <= (s_axis_tuser == KIND_TICK) ? S_ACC : S_OUT;
				end
				S_ACC: if (!acc_busy && !acc_start) begin
					nclk_q <= acc_clocks;
					st_q <= (acc_clocks == 3'd0) ? S_SMP : S_CLK;
				end
				S_CLK: begin
					nclk_q <= nclk_q - 3'd1;
					st_q <= S_CLKW;
				end
				S_CLKW: st_q <= (nclk_q == 3'd0) ? S_WAV : S_CLK;
				// wave ram read follows the last carrier position update
				S_WAV: st_q <= S_SMP;
				S_SMP: begin
					num <= (14'(wave_q) * 14'(k)) << 2;
					st_q <= S_SMP2;
				end
				S_SMP2: begin
					case (regs_q[9][1:0])
						2'd0: smp_q <= 12'(num >> 1);
						2'd1: smp_q <= 12'(({15'd0, num} * 29'd21846) >> 16);
						2'd2: smp_q <= 12'(num >> 2);
						default: smp_q <= 12'(({15'd0, num} * 29'd13108) >> 16);
					endcase
					st_q <= S_OUT;
				end
				S_OUT: if (m_axis_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/wfm_checker.sv
`default_nettype none
module wfm_checker (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	input wire s_axis_tready,
	input wire m_axis_tvalid,
	input wire m_axis_tready,
	input wire [23:0] m_axis_tdata
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("overlap");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[19:8] == 12'd0))
		else $error("both fields");
endmodule
bind wavetable_fm_sound_channel wfm_checker u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
`default_nettype wire
